### rtl/tgpi_pkg.sv
// ----------------------------------------------------------------------------
// tgpi_pkg
// Shared widths, codes and types of the tray grid point interpolator.
// ----------------------------------------------------------------------------
package tgpi_pkg;

    localparam int MAX_HOLES_DEF = 64;
    localparam int EMIT_CAP      = 64;

    localparam int IDX_W   = 6;
    localparam int POS_W   = 32;
    localparam int CFG_W   = 7;
    localparam int MODE_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int DATA_W  = 136;
    localparam int NDIM    = 3;
    localparam int WORD_W  = 4 * POS_W;

    localparam int FRAC_W  = 16;
    localparam int DIFF_W  = POS_W + 1;
    localparam int NUM_W   = POS_W + FRAC_W;
    localparam int SPAN_W  = NUM_W + 2;
    localparam int SUM_W   = SPAN_W + 8;
    localparam int QUO_W   = SUM_W - FRAC_W;
    localparam int TOT_W   = QUO_W + 1;
    localparam int NCNT_W  = 2 * CFG_W;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;

    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_FRM  = 2'd2;

    typedef enum logic [1:0] {
        K_WRITE,
        K_COMPUTE,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   idx;
        logic               in_store;
        logic [POS_W-1:0]   r;
        logic [POS_W-1:0]   z;
        logic [POS_W-1:0]   y;
        logic [POS_W-1:0]   x;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        logic             frm;
    } t_cfg;

    typedef struct packed {
        logic clearing;
        logic idle;
    } t_bstat;

endpackage

### rtl/tray_grid_point_interpolator.sv
// ----------------------------------------------------------------------------
// tray_grid_point_interpolator
// Point table of a tray grid with write, read and grid compute commands.
// ----------------------------------------------------------------------------
// Input transactions carry the command in tuser (0 write, 1 compute, 2 read)
// and the hole index and X, Y, Z, R position in tdata. Output transactions
// carry the hole index and its position, with tlast on the final result.
// Registers rows, cols and first-row mode are written on the configuration
// channel, which is always ready; the user must write them only while the
// block is idle, which the block does not enforce. A front stage classifies
// commands into a two-entry queue; a back-end sequencer owns the single-port
// point memory and the result register. A read loads its word as it leaves
// the queue and moves it to the result register once that is free.
// A compute reads three points, serially divides the row spans and, unless
// in first-row mode, the column spans, skipping zero divisors, then places
// and emits each hole. After reset the memory is cleared address by address,
// during which no input transaction is accepted. A stalled receiver holds
// the result register and the sequencer; the queue accepts until it is full.
// ----------------------------------------------------------------------------
module tray_grid_point_interpolator
    import tgpi_pkg::*;
#(
    parameter int MAX_HOLES = MAX_HOLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // tdata: hole_index, in_x, in_y, in_z, in_r, zero pad
    input  logic [DATA_W-1:0] i_s_tdata,
    // tuser: mode
    input  logic [MODE_W-1:0] i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // tdata: out_index, out_x, out_y, out_z, out_r, zero pad
    output logic [DATA_W-1:0] o_m_tdata,
    output logic              o_m_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cfg   r_cfg;
    t_cmd   f_cmd;
    t_cmd   q_cmd;
    t_bstat b_stat;
    logic   f_push;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows <= CFG_W'(4);
            r_cfg.cols <= CFG_W'(4);
            r_cfg.frm  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS: r_cfg.rows <= i_cfg_data;
                CFG_COLS: r_cfg.cols <= i_cfg_data;
                CFG_FRM:  r_cfg.frm  <= i_cfg_data[0];
                default:  r_cfg      <= r_cfg;
            endcase
        end
    end

    tgpi_front #(
        .MAX_HOLES (MAX_HOLES)
    ) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .i_block    (b_stat.clearing),
        .o_push     (f_push),
        .o_cmd      (f_cmd)
    );

    tgpi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tgpi_back #(
        .MAX_HOLES (MAX_HOLES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_stat     (b_stat)
    );

    a_no_result_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        b_stat.clearing |-> !o_m_tvalid
    ) else $error("result presented during memory clearing");

    a_no_push_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !f_push
    ) else $error("command pushed into a full queue");

    a_pop_only_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_valid && b_stat.idle)
    ) else $error("queue popped without a command or while busy");

endmodule

### rtl/tgpi_front.sv
// ----------------------------------------------------------------------------
// tgpi_front
// Accepts input transactions, classifies them and drops unused codes.
// ----------------------------------------------------------------------------
module tgpi_front
    import tgpi_pkg::*;
#(
    parameter int MAX_HOLES = MAX_HOLES_DEF
) (
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,
    input  logic [MODE_W-1:0] i_s_tuser,
    input  logic              i_q_full,
    input  logic              i_block,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic known;

    assign o_s_tready = !i_q_full && !i_block;

    always_comb begin
        o_cmd.idx      = i_s_tdata[IDX_W-1:0];
        o_cmd.x        = i_s_tdata[IDX_W +: POS_W];
        o_cmd.y        = i_s_tdata[IDX_W + POS_W +: POS_W];
        o_cmd.z        = i_s_tdata[IDX_W + 2*POS_W +: POS_W];
        o_cmd.r        = i_s_tdata[IDX_W + 3*POS_W +: POS_W];
        o_cmd.in_store = {{(32-IDX_W){1'b0}}, o_cmd.idx} < 32'(MAX_HOLES);
        known          = 1'b1;
        case (i_s_tuser)
            MODE_WRITE:   o_cmd.kind = K_WRITE;
            MODE_COMPUTE: o_cmd.kind = K_COMPUTE;
            MODE_READ:    o_cmd.kind = K_READ;
            default: begin
                o_cmd.kind = K_WRITE;
                known      = 1'b0;
            end
        endcase
    end

    assign o_push = i_s_tvalid && o_s_tready && known;

endmodule

### rtl/tgpi_queue.sv
// ----------------------------------------------------------------------------
// tgpi_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module tgpi_queue
    import tgpi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_slot[r_wp] <= i_cmd;
                r_wp         <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/tgpi_div.sv
// ----------------------------------------------------------------------------
// tgpi_div
// Serial restoring divider for the scaled spans, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tgpi_div
    import tgpi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIFF_W-1:0] i_num,
    input  logic [CFG_W-1:0]  i_den,
    output logic              o_done,
    output logic [SPAN_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic [CFG_W-1:0]  r_den;
    logic [CFG_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_acc;

    logic [DIFF_W-1:0] num_abs;
    logic [CFG_W:0]    rem_sh;
    logic              ge;
    logic [CFG_W:0]    rem_nx;
    logic [SPAN_W-1:0] quo_mag;

    always_comb begin
        num_abs = i_num[DIFF_W-1] ? (~i_num + 1'b1) : i_num;
        rem_sh  = {r_rem, r_acc[NUM_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_nx  = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
        quo_mag = {{(SPAN_W-NUM_W){1'b0}}, r_acc};
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (~quo_mag + 1'b1) : quo_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[DIFF_W-1];
                r_den  <= i_den;
                r_rem  <= '0;
                r_acc  <= {num_abs[POS_W-1:0], {FRAC_W{1'b0}}};
            end else if (r_busy) begin
                r_acc <= {r_acc[NUM_W-2:0], ge};
                r_rem <= rem_nx[CFG_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/tgpi_back.sv
// ----------------------------------------------------------------------------
// tgpi_back
// Point table, grid sequencer and result register of the interpolator.
// ----------------------------------------------------------------------------
module tgpi_back
    import tgpi_pkg::*;
#(
    parameter int MAX_HOLES = MAX_HOLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_q_valid,
    input  t_cmd              i_q_cmd,
    output logic              o_q_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,
    output logic              o_m_tlast,
    output t_bstat            o_stat
);

    localparam int AW = $clog2(MAX_HOLES);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ_OUT,
        S_LOAD_A,
        S_LOAD_C,
        S_LOAD_B,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SUM,
        S_PLACE,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr;
    logic [WORD_W-1:0]  r_mem [MAX_HOLES];
    logic [WORD_W-1:0]  r_rd;

    logic               r_ovalid;
    logic [WORD_W-1:0]  r_odata;
    logic [IDX_W-1:0]   r_oidx;
    logic               r_olast;

    logic [IDX_W-1:0]   r_idx;
    logic               r_instore;
    logic [POS_W-1:0]   r_a [NDIM];
    logic [POS_W-1:0]   r_b [NDIM];
    logic [POS_W-1:0]   r_c [NDIM];
    logic [POS_W-1:0]   r_ar;
    logic [1:0]         r_dim;
    logic               r_colpass;
    logic [SPAN_W-1:0]  r_rspan [NDIM];
    logic [SPAN_W-1:0]  r_cspan [NDIM];
    logic [SUM_W-1:0]   r_rowacc [NDIM];
    logic [SUM_W-1:0]   r_colacc [NDIM];
    logic [SUM_W-1:0]   r_sum [NDIM];
    logic [AW-1:0]      r_h;
    logic [CFG_W-1:0]   r_i;
    logic [AW-1:0]      r_lasth;
    logic [IDX_W-1:0]   r_k;
    logic [IDX_W-1:0]   r_emitlast;

    logic               m_we;
    logic [AW-1:0]      m_waddr;
    logic [WORD_W-1:0]  m_wdata;
    logic               m_re;
    logic [AW-1:0]      m_raddr;

    logic [NCNT_W-1:0]  n_holes;
    logic [NCNT_W-1:0]  ic_full;
    logic               skip;
    logic               out_free;
    logic [CFG_W-1:0]   div_den;
    logic [DIFF_W-1:0]  div_num;
    logic               div_start;
    logic               div_done;
    logic [SPAN_W-1:0]  div_quo;
    logic               last_pass;

    logic [SUM_W-1:0]   v_round [NDIM];
    logic [QUO_W-1:0]   v_q [NDIM];
    logic [POS_W-1:0]   v_base [NDIM];
    logic [TOT_W-1:0]   v_tot [NDIM];
    logic [POS_W-1:0]   v_pos [NDIM];

    always_comb begin
        n_holes  = NCNT_W'(i_cfg.rows) * NCNT_W'(i_cfg.cols);
        ic_full  = NCNT_W'(i_cfg.rows - 1'b1) * NCNT_W'(i_cfg.cols);
        skip     = (n_holes <= NCNT_W'(1)) || (32'(n_holes) > 32'(MAX_HOLES));
        out_free = !r_ovalid || i_m_tready;
        div_den  = r_colpass ? (i_cfg.cols - 1'b1) : (i_cfg.rows - 1'b1);
        div_num  = r_colpass
                 ? ({r_b[r_dim][POS_W-1], r_b[r_dim]} - {r_a[r_dim][POS_W-1], r_a[r_dim]})
                 : ({r_c[r_dim][POS_W-1], r_c[r_dim]} - {r_a[r_dim][POS_W-1], r_a[r_dim]});
        div_start = (r_state == S_DIV_GO) && (div_den != '0);
        last_pass = (r_dim == 2'd2) && (i_cfg.frm || r_colpass);
    end

    always_comb begin
        for (int d = 0; d < NDIM; d++) begin
            v_round[d] = r_sum[d] + SUM_W'(1 << (FRAC_W - 1));
            v_q[d]     = v_round[d][SUM_W-1:FRAC_W];
            v_base[d]  = i_cfg.frm ? r_rd[d*POS_W +: POS_W] : r_a[d];
            v_tot[d]   = {{(TOT_W-POS_W){v_base[d][POS_W-1]}}, v_base[d]}
                       + {v_q[d][QUO_W-1], v_q[d]};
            if (v_tot[d][TOT_W-1:POS_W-1] == '0 || v_tot[d][TOT_W-1:POS_W-1] == '1) begin
                v_pos[d] = v_tot[d][POS_W-1:0];
            end else if (v_tot[d][TOT_W-1]) begin
                v_pos[d] = {1'b1, {(POS_W-1){1'b0}}};
            end else begin
                v_pos[d] = {1'b0, {(POS_W-1){1'b1}}};
            end
        end
    end

    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_h;
        m_wdata = {r_ar, v_pos[2], v_pos[1], v_pos[0]};
        m_re    = 1'b0;
        m_raddr = '0;
        case (r_state)
            S_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                m_wdata = '0;
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.kind)
                        K_WRITE: begin
                            m_we    = i_q_cmd.in_store;
                            m_waddr = AW'(i_q_cmd.idx);
                            m_wdata = {i_q_cmd.r, i_q_cmd.z, i_q_cmd.y, i_q_cmd.x};
                        end
                        K_READ: begin
                            m_re    = i_q_cmd.in_store;
                            m_raddr = AW'(i_q_cmd.idx);
                        end
                        K_COMPUTE: begin
                            m_re    = !skip;
                        end
                        default: begin
                            m_re = 1'b0;
                        end
                    endcase
                end
            end
            S_LOAD_A: begin
                m_re    = 1'b1;
                m_raddr = AW'(ic_full);
            end
            S_LOAD_C: begin
                m_re    = 1'b1;
                m_raddr = AW'(i_cfg.cols - 1'b1);
            end
            S_SUM: begin
                m_re    = i_cfg.frm;
                m_raddr = AW'(r_i);
            end
            S_PLACE: begin
                m_we = 1'b1;
            end
            S_EMIT_RD: begin
                m_re    = 1'b1;
                m_raddr = AW'(r_k);
            end
            default: begin
                m_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mem[m_waddr] <= m_wdata;
        end
        if (m_re) begin
            r_rd <= r_mem[m_raddr];
        end
    end

    tgpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_q_pop         = (r_state == S_IDLE) && i_q_valid;
    assign o_m_tvalid      = r_ovalid;
    assign o_m_tdata       = {{(DATA_W-WORD_W-IDX_W){1'b0}}, r_odata, r_oidx};
    assign o_m_tlast       = r_olast;
    assign o_stat.clearing = r_state == S_CLEAR;
    assign o_stat.idle     = r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(MAX_HOLES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_idx     <= i_q_cmd.idx;
                    r_instore <= i_q_cmd.in_store;
                    if (i_q_valid) begin
                        case (i_q_cmd.kind)
                            K_READ: begin
                                r_state <= S_READ_OUT;
                            end
                            K_COMPUTE: begin
                                r_lasth <= AW'(n_holes - 1'b1);
                                r_emitlast <= (n_holes > NCNT_W'(EMIT_CAP))
                                            ? IDX_W'(EMIT_CAP - 1)
                                            : IDX_W'(n_holes - 1'b1);
                                if (!skip) begin
                                    r_state <= S_LOAD_A;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_instore ? r_rd : '0;
                        r_oidx   <= r_idx;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_LOAD_A: begin
                    for (int d = 0; d < NDIM; d++) begin
                        r_a[d] <= r_rd[d*POS_W +: POS_W];
                    end
                    r_ar    <= r_rd[3*POS_W +: POS_W];
                    r_state <= S_LOAD_C;
                end
                S_LOAD_C: begin
                    for (int d = 0; d < NDIM; d++) begin
                        r_c[d] <= r_rd[d*POS_W +: POS_W];
                    end
                    r_state <= S_LOAD_B;
                end
                S_LOAD_B: begin
                    for (int d = 0; d < NDIM; d++) begin
                        r_b[d] <= r_rd[d*POS_W +: POS_W];
                    end
                    r_dim     <= '0;
                    r_colpass <= 1'b0;
                    r_state   <= S_DIV_GO;
                end
                S_DIV_GO, S_DIV_WAIT: begin
                    if ((r_state == S_DIV_GO && div_den == '0) || div_done) begin
                        if (r_colpass) begin
                            r_cspan[r_dim] <= div_done ? div_quo : '0;
                        end else begin
                            r_rspan[r_dim] <= div_done ? div_quo : '0;
                        end
                        if (last_pass) begin
                            r_h <= i_cfg.frm ? AW'(i_cfg.cols) : '0;
                            r_i <= '0;
                            r_k <= '0;
                            for (int d = 0; d < NDIM; d++) begin
                                r_colacc[d] <= '0;
                                r_rowacc[d] <= '0;
                            end
                            if (i_cfg.frm && i_cfg.rows == CFG_W'(1)) begin
                                r_state <= S_EMIT_RD;
                            end else begin
                                r_state <= S_SUM;
                            end
                            if (i_cfg.frm) begin
                                for (int d = 0; d < NDIM - 1; d++) begin
                                    r_rowacc[d] <= {{(SUM_W-SPAN_W){r_rspan[d][SPAN_W-1]}},
                                                    r_rspan[d]};
                                end
                                r_rowacc[NDIM-1] <= div_done
                                    ? {{(SUM_W-SPAN_W){div_quo[SPAN_W-1]}}, div_quo}
                                    : '0;
                            end
                        end else begin
                            r_state <= S_DIV_GO;
                            if (r_dim == 2'd2) begin
                                r_dim     <= '0;
                                r_colpass <= 1'b1;
                            end else begin
                                r_dim <= r_dim + 1'b1;
                            end
                        end
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_SUM: begin
                    for (int d = 0; d < NDIM; d++) begin
                        r_sum[d] <= i_cfg.frm ? r_rowacc[d] : (r_rowacc[d] + r_colacc[d]);
                    end
                    r_state <= S_PLACE;
                end
                S_PLACE: begin
                    r_h <= r_h + 1'b1;
                    if (r_i == i_cfg.cols - 1'b1) begin
                        r_i <= '0;
                        for (int d = 0; d < NDIM; d++) begin
                            r_colacc[d] <= '0;
                            r_rowacc[d] <= r_rowacc[d]
                                + {{(SUM_W-SPAN_W){r_rspan[d][SPAN_W-1]}}, r_rspan[d]};
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                        for (int d = 0; d < NDIM; d++) begin
                            r_colacc[d] <= r_colacc[d]
                                + {{(SUM_W-SPAN_W){r_cspan[d][SPAN_W-1]}}, r_cspan[d]};
                        end
                    end
                    r_state <= (r_h == r_lasth) ? S_EMIT_RD : S_SUM;
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_OUT;
                end
                S_EMIT_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_rd;
                        r_oidx   <= r_k;
                        r_olast  <= r_k == r_emitlast;
                        r_k      <= r_k + 1'b1;
                        r_state  <= (r_k == r_emitlast) ? S_IDLE : S_EMIT_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### bench/tray_grid_point_interpolator_tb.sv
// ----------------------------------------------------------------------------
// tray_grid_point_interpolator_tb
// Self-checking bench: a directed table and grid corner cases followed by
// random write, read, compute and unused-code traffic over several grid
// settings, with sender and receiver idling and a long receiver hold-off,
// all results checked against a local predictor.
module tray_grid_point_interpolator_tb;
    import tgpi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int DRAIN_CYCLES = 800;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] x, y, z, r;
        logic             last;
    } hole_rec_t;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  idx;
        logic [POS_W-1:0]  x, y, z, r;
        bit                zero_read;
    } dir_row_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata = '0;
    logic [MODE_W-1:0] i_s_tuser = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;
    logic              o_m_tlast;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    tray_grid_point_interpolator dut (.*);

    always #1ns i_clk = ~i_clk;

    logic [POS_W-1:0] tbl_x [64], tbl_y [64], tbl_z [64], tbl_r [64];
    int unsigned      grid_rows = 4, grid_cols = 4;
    bit               row_mode = 1'b0;
    hole_rec_t        hole_q [$];
    int               fail_cnt = 0;
    int               src_pct = 0, snk_pct = 0;
    int               hold_left = 0;
    int unsigned      cycle_cnt = 0;

    function automatic longint span(logic [POS_W-1:0] p, logic [POS_W-1:0] a,
                                    int unsigned n);
        longint d;
        if (n <= 1) return 0;
        d = longint'($signed(p)) - longint'($signed(a));
        return (d * 65536) / longint'(n - 1);
    endfunction

    function automatic logic [POS_W-1:0] place(longint base, longint sum);
        longint v;
        v = base + ((sum + 32768) >>> 16);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[POS_W-1:0];
    endfunction

    function automatic void push_hole(int unsigned h, bit last);
        hole_rec_t e;
        e.idx  = h[IDX_W-1:0];
        e.x    = tbl_x[h];
        e.y    = tbl_y[h];
        e.z    = tbl_z[h];
        e.r    = tbl_r[h];
        e.last = last;
        hole_q.insert(hole_q.size(), e);
    endfunction

    function automatic void grid_compute();
        int unsigned n, ib, ic, h;
        longint rsx, rsy, rsz, csx, csy, csz, ax, ay, az;
        logic [POS_W-1:0] ar;
        n = grid_rows * grid_cols;
        if (n <= 1 || n > 64) return;
        ib = grid_cols - 1;
        ic = (grid_rows - 1) * grid_cols;
        ax = $signed(tbl_x[0]);
        ay = $signed(tbl_y[0]);
        az = $signed(tbl_z[0]);
        ar = tbl_r[0];
        rsx = span(tbl_x[ic], tbl_x[0], grid_rows);
        rsy = span(tbl_y[ic], tbl_y[0], grid_rows);
        rsz = span(tbl_z[ic], tbl_z[0], grid_rows);
        csx = span(tbl_x[ib], tbl_x[0], grid_cols);
        csy = span(tbl_y[ib], tbl_y[0], grid_cols);
        csz = span(tbl_z[ib], tbl_z[0], grid_cols);
        for (int unsigned j = 0; j < grid_rows; j++) begin
            for (int unsigned i = 0; i < grid_cols; i++) begin
                h = j * grid_cols + i;
                if (row_mode) begin
                    if (j != 0) begin
                        tbl_x[h] = place($signed(tbl_x[i]), longint'(j) * rsx);
                        tbl_y[h] = place($signed(tbl_y[i]), longint'(j) * rsy);
                        tbl_z[h] = place($signed(tbl_z[i]), longint'(j) * rsz);
                        tbl_r[h] = ar;
                    end
                end else begin
                    tbl_x[h] = place(ax, longint'(j) * rsx + longint'(i) * csx);
                    tbl_y[h] = place(ay, longint'(j) * rsy + longint'(i) * csy);
                    tbl_z[h] = place(az, longint'(j) * rsz + longint'(i) * csz);
                    tbl_r[h] = ar;
                end
            end
        end
        for (int unsigned k = 0; k < n; k++) push_hole(k, k + 1 == n);
    endfunction

    function automatic void tray_predict(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
                                         logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                         logic [POS_W-1:0] z, logic [POS_W-1:0] r);
        case (mode)
            MODE_WRITE: begin
                tbl_x[idx] = x;
                tbl_y[idx] = y;
                tbl_z[idx] = z;
                tbl_r[idx] = r;
            end
            MODE_COMPUTE: grid_compute();
            MODE_READ: push_hole(idx, 1'b1);
            default: ;
        endcase
    endfunction

    task automatic send_item(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
                             logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [POS_W-1:0] z, logic [POS_W-1:0] r,
                             bit zero_read);
        hole_rec_t e;
        while ($urandom_range(99) < src_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {2'b00, r, z, y, x, idx};
        do @(posedge i_clk); while (!o_s_tready);
        if (zero_read) begin
            e = '{idx: idx, x: '0, y: '0, z: '0, r: '0, last: 1'b1};
            hole_q.insert(hole_q.size(), e);
        end else begin
            tray_predict(mode, idx, x, y, z, r);
        end
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (hole_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid(int unsigned rows, int unsigned cols, bit frm);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= rows[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_COLS;
        i_cfg_data  <= cols[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_FRM;
        i_cfg_data  <= {6'd0, frm};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        grid_rows = rows;
        grid_cols = cols;
        row_mode  = frm;
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        if ($urandom_range(1)) return $urandom;
        return $urandom_range(200000) - 100000;
    endfunction

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_pct);
        end
    end

    always @(posedge i_clk) begin
        hole_rec_t e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (hole_q.size() == 0) begin
                $display("%0t: unexpected result idx=%0d", $time, o_m_tdata[5:0]);
                fail_cnt++;
            end else begin
                e = hole_q.pop_front();
                if (o_m_tdata[5:0] !== e.idx || o_m_tdata[37:6] !== e.x ||
                    o_m_tdata[69:38] !== e.y || o_m_tdata[101:70] !== e.z ||
                    o_m_tdata[133:102] !== e.r || o_m_tlast !== e.last) begin
                    $display("%0t: mismatch expected idx=%0d x=%h y=%h z=%h r=%h last=%b",
                             $time, e.idx, e.x, e.y, e.z, e.r, e.last);
                    $display("%0t:          actual   idx=%0d x=%h y=%h z=%h r=%h last=%b",
                             $time, o_m_tdata[5:0], o_m_tdata[37:6], o_m_tdata[69:38],
                             o_m_tdata[101:70], o_m_tdata[133:102], o_m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    localparam logic [POS_W-1:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] PMIN = 32'h8000_0000;

    dir_row_t dir_tab [] = '{
        '{MODE_READ,    6'd0,  '0, '0, '0, '0, 1'b1},
        '{MODE_READ,    6'd63, '0, '0, '0, '0, 1'b1},
        '{MODE_WRITE,   6'd0,  32'd1000, 32'd2000, 32'd3000, 32'd45000, 1'b0},
        '{MODE_WRITE,   6'd3,  32'd4001, 32'd2000, 32'd2999, 32'd7, 1'b0},
        '{MODE_WRITE,   6'd12, 32'd1000, 32'd9000, 32'd3001, 32'd9, 1'b0},
        '{MODE_COMPUTE, 6'd0,  '0, '0, '0, '0, 1'b0},
        '{MODE_READ,    6'd5,  '0, '0, '0, '0, 1'b0},
        '{MODE_NOP,     6'd7,  '1, '1, '1, '1, 1'b0},
        '{MODE_WRITE,   6'd63, PMAX, PMIN, '1, PMAX, 1'b0},
        '{MODE_READ,    6'd63, '0, '0, '0, '0, 1'b0},
        '{MODE_WRITE,   6'd0,  PMIN, PMAX, PMIN, PMIN, 1'b0},
        '{MODE_WRITE,   6'd3,  PMAX, PMIN, PMAX, '0, 1'b0},
        '{MODE_WRITE,   6'd12, PMAX, PMIN, PMIN, '1, 1'b0},
        '{MODE_COMPUTE, 6'd0,  '0, '0, '0, '0, 1'b0},
        '{MODE_READ,    6'd15, '0, '0, '0, '0, 1'b0}
    };

    initial begin
        int unsigned rows, cols, key;
        logic [IDX_W-1:0] idx;
        int pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int h = 0; h < 64; h++) begin
            tbl_x[h] = '0; tbl_y[h] = '0; tbl_z[h] = '0; tbl_r[h] = '0;
        end
        foreach (dir_tab[k])
            send_item(dir_tab[k].mode, dir_tab[k].idx, dir_tab[k].x, dir_tab[k].y,
                      dir_tab[k].z, dir_tab[k].r, dir_tab[k].zero_read);
        set_grid(1, 1, 1'b0);
        send_item(MODE_COMPUTE, 6'd0, '0, '0, '0, '0, 1'b0);
        set_grid(64, 1, 1'b0);
        send_item(MODE_WRITE, 6'd0, 32'd10, 32'd20, 32'd30, 32'd40, 1'b0);
        send_item(MODE_WRITE, 6'd63, 32'd640, PMIN, 32'd30, 32'd1, 1'b0);
        send_item(MODE_COMPUTE, 6'd0, '0, '0, '0, '0, 1'b0);
        set_grid(64, 64, 1'b1);
        send_item(MODE_COMPUTE, 6'd0, '0, '0, '0, '0, 1'b0);
        set_grid(1, 64, 1'b1);
        send_item(MODE_COMPUTE, 6'd0, '0, '0, '0, '0, 1'b0);

        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin src_pct = 35; snk_pct = 63; end
                1: begin src_pct = 63; snk_pct = 35; end
                default: begin src_pct = 0; snk_pct = 0; end
            endcase
            pick = $urandom_range(5);
            if (pick == 0) begin
                rows = 64; cols = $urandom_range(1) ? 1 : $urandom_range(2, 64);
            end else if (pick == 1) begin
                rows = 1; cols = $urandom_range(1, 64);
            end else begin
                rows = $urandom_range(1, 8); cols = $urandom_range(1, 8);
            end
            set_grid(rows, cols, 1'($urandom_range(1)));
            if (ph == 6) hold_left = 600;
            for (int k = 0; k < 24; k++) begin
                pick = $urandom_range(99);
                case ($urandom_range(2))
                    0: key = 0;
                    1: key = cols - 1;
                    default: key = (rows - 1) * cols;
                endcase
                idx = (pick < 25) ? key[IDX_W-1:0] : IDX_W'($urandom);
                if (pick < 50 || pick >= 80)
                    send_item(MODE_WRITE, idx, rand_pos(), rand_pos(), rand_pos(),
                              $urandom, 1'b0);
                else if (pick < 65)
                    send_item(MODE_READ, idx, $urandom, $urandom, $urandom, $urandom, 1'b0);
                else if (pick < 75)
                    send_item(MODE_COMPUTE, idx, $urandom, $urandom, $urandom, $urandom,
                              1'b0);
                else
                    send_item(MODE_NOP, idx, $urandom, $urandom, $urandom, $urandom, 1'b0);
            end
        end

        wait_idle();
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
